[design/hfa_pkg.sv]
// Shared constants, types and helpers for the 3x3 hole-filling block.
`timescale 1ns / 1ps
`default_nettype none

package hfa_pkg;

  // Frame geometry
  localparam int MAX_WIDTH   = 2048;
  localparam int CNT_LIMIT   = 2048;
  localparam int ADDR_W      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CNT_W       = 11;
  localparam int DIM_W       = 12;
  localparam int PIX_W       = 8;
  localparam int W_CAP_INT   = (MAX_WIDTH < CNT_LIMIT) ? MAX_WIDTH : CNT_LIMIT;
  localparam logic [DIM_W-1:0] W_CAP = DIM_W'(W_CAP_INT);
  localparam logic [DIM_W-1:0] H_CAP = DIM_W'(CNT_LIMIT);
  localparam logic [DIM_W-1:0] DIM_MIN = DIM_W'(3);
  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  // Neighborhood
  localparam int NB_N       = 9;
  localparam int CENTER_IDX = 4;
  localparam int WIN_N      = 6;

  // Mean arithmetic: sum of nine pixels, count up to nine
  localparam int SUM_W   = 12;
  localparam int CNTN_W  = 4;
  localparam int NUM_W   = SUM_W + 1;
  localparam int DEN_W   = CNTN_W + 1;
  localparam int DIV_STEPS = PIX_W;
  localparam int STEP_W  = $clog2(DIV_STEPS);

  // Queue between front and back
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // One classified pixel handed from front to back
  typedef struct packed {
    logic [CNT_W-1:0]          row;
    logic [CNT_W-1:0]          col;
    logic [PIX_W-1:0]          px;
    logic                      interior;
    logic                      border;
    logic [NB_N-1:0][PIX_W-1:0] nb;
  } job_t;

  typedef enum logic {
    F_IDLE,
    F_PROC
  } fstate_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SUM,
    B_DIV,
    B_EMIT_INT,
    B_EMIT_BRD
  } bstate_t;

  // Clamp a frame dimension to 3..hi
  function automatic logic [DIM_W-1:0] dim_clamp(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] hi);
    logic [DIM_W-1:0] res;
    if (v < DIM_MIN) begin
      res = DIM_MIN;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[design/hfa_if.sv]
// Request channel interfaces: pixel input, result output and configuration writes.
`timescale 1ns / 1ps
`default_nettype none

interface hfa_in_if;
  import hfa_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             frame_start;
  modport source (output valid, pixel, frame_start, input ready);
  modport sink   (input valid, pixel, frame_start, output ready);
endinterface

interface hfa_out_if;
  import hfa_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] out_row;
  logic [CNT_W-1:0] out_col;
  logic [PIX_W-1:0] out_pixel;
  logic             last_of_item;
  modport source (output valid, out_row, out_col, out_pixel, last_of_item, input ready);
  modport sink   (input valid, out_row, out_col, out_pixel, last_of_item, output ready);
endinterface

interface hfa_cfg_if;
  import hfa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/hfa_front.sv]
// Front end: position tracking, line stores, window and classification of each pixel.
`timescale 1ns / 1ps
`default_nettype none

module hfa_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [hfa_pkg::DIM_W-1:0] width,
  input  logic [hfa_pkg::DIM_W-1:0] height,
  hfa_in_if.sink                  in_ch,
  output logic                    push_valid,
  input  logic                    push_ready,
  output hfa_pkg::job_t           push_data
);
  import hfa_pkg::*;

  fstate_t          state_r, state_nxt;
  logic [CNT_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] col_r, col_nxt;
  logic [CNT_W-1:0] r_r, c_r;
  logic [PIX_W-1:0] px_r;
  logic [PIX_W-1:0] prev_rd_r, prev2_rd_r;
  logic [PIX_W-1:0] win_r [WIN_N];

  logic [PIX_W-1:0] prev_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] prev2_mem [MAX_WIDTH];

  logic             accept, commit, restart;
  logic [CNT_W-1:0] cur_r, cur_c;
  logic [DIM_W-1:0] c_inc, r_inc;

  assign accept = in_ch.valid && in_ch.ready;
  assign commit = push_valid && push_ready;

  // Position of the arriving pixel, and of the one after it
  always_comb begin
    restart = in_ch.frame_start || ({1'b0, col_r} >= width) || ({1'b0, row_r} >= height);
    cur_r   = restart ? '0 : row_r;
    cur_c   = restart ? '0 : col_r;
    c_inc   = DIM_W'(cur_c) + DIM_W'(1);
    r_inc   = DIM_W'(cur_r) + DIM_W'(1);
    if (c_inc >= width) begin
      col_nxt = '0;
      row_nxt = (r_inc >= height) ? '0 : r_inc[CNT_W-1:0];
    end else begin
      col_nxt = c_inc[CNT_W-1:0];
      row_nxt = cur_r;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (accept) state_nxt = F_PROC;
      end
      F_PROC: begin
        if (commit) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ch.ready = 1'b0;
    push_valid  = 1'b0;
    case (state_r)
      F_IDLE:  in_ch.ready = 1'b1;
      F_PROC:  push_valid  = 1'b1;
      default: ;
    endcase
  end

  // Classified job: neighborhood in row-major order, newest pixel last
  always_comb begin
    push_data.row      = r_r;
    push_data.col      = c_r;
    push_data.px       = px_r;
    push_data.interior = (r_r >= CNT_W'(2)) && (c_r >= CNT_W'(2));
    push_data.border   = (r_r == '0) || ({1'b0, r_r} == height - DIM_W'(1)) ||
                         (c_r == '0) || ({1'b0, c_r} == width - DIM_W'(1));
    push_data.nb[0] = win_r[0];
    push_data.nb[1] = win_r[3];
    push_data.nb[2] = prev2_rd_r;
    push_data.nb[3] = win_r[1];
    push_data.nb[4] = win_r[4];
    push_data.nb[5] = prev_rd_r;
    push_data.nb[6] = win_r[2];
    push_data.nb[7] = win_r[5];
    push_data.nb[8] = px_r;
  end

  // Control state and window
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      row_r   <= '0;
      col_r   <= '0;
      for (int i = 0; i < WIN_N; i++) win_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        row_r <= row_nxt;
        col_r <= col_nxt;
      end
      if (commit) begin
        win_r[0] <= win_r[3];
        win_r[1] <= win_r[4];
        win_r[2] <= win_r[5];
        win_r[3] <= prev2_rd_r;
        win_r[4] <= prev_rd_r;
        win_r[5] <= px_r;
      end
    end
  end

  // Captured pixel and position
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r <= in_ch.pixel;
      r_r  <= cur_r;
      c_r  <= cur_c;
    end
  end

  // Line stores: read on accept, write back when the job leaves
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_rd_r  <= prev_mem[ADDR_W'(cur_c)];
      prev2_rd_r <= prev2_mem[ADDR_W'(cur_c)];
    end
    if (commit) begin
      prev_mem[ADDR_W'(c_r)]  <= px_r;
      prev2_mem[ADDR_W'(c_r)] <= prev_rd_r;
    end
  end

endmodule

`default_nettype wire

[design/hfa_queue.sv]
// Small FIFO of classified jobs between front and back.
`timescale 1ns / 1ps
`default_nettype none

module hfa_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  hfa_pkg::job_t push_data,
  output logic          pop_valid,
  input  logic          pop_ready,
  output hfa_pkg::job_t pop_data
);
  import hfa_pkg::*;

  job_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

[design/hfa_back.sv]
// Back end: neighbor mean by bit-serial division, and result sequencing.
`timescale 1ns / 1ps
`default_nettype none

module hfa_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  hfa_pkg::job_t pop_data,
  hfa_out_if.source     out_ch
);
  import hfa_pkg::*;

  bstate_t           state_r, state_nxt;
  job_t              job_r;
  logic [PIX_W-1:0]  val_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [PIX_W-1:0]  numlo_r;
  logic [PIX_W-1:0]  quo_r;
  logic [STEP_W-1:0] step_r;

  logic              pop, out_take;
  logic [SUM_W-1:0]  sum;
  logic [CNTN_W-1:0] cnt;
  logic [NUM_W-1:0]  num;
  logic [DEN_W:0]    trial;
  logic              qbit;
  logic [DEN_W-1:0]  rem_step;

  assign pop      = pop_valid && pop_ready;
  assign out_take = out_ch.valid && out_ch.ready;

  // Sum and count of nonzero neighbors
  always_comb begin
    sum = '0;
    cnt = '0;
    for (int i = 0; i < NB_N; i++) begin
      if (job_r.nb[i] != '0) begin
        sum = sum + SUM_W'(job_r.nb[i]);
        cnt = cnt + CNTN_W'(1);
      end
    end
    num = {sum, 1'b0} + NUM_W'(cnt);
  end

  // One restoring division step
  always_comb begin
    trial    = {rem_r, numlo_r[PIX_W-1]};
    qbit     = (trial >= {1'b0, den_r});
    rem_step = qbit ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE: begin
        if (pop) begin
          if (pop_data.interior) begin
            state_nxt = (pop_data.nb[CENTER_IDX] == '0) ? B_SUM : B_EMIT_INT;
          end else if (pop_data.border) begin
            state_nxt = B_EMIT_BRD;
          end
        end
      end
      B_SUM: begin
        state_nxt = (cnt == '0) ? B_EMIT_INT : B_DIV;
      end
      B_DIV: begin
        if (step_r == '0) state_nxt = B_EMIT_INT;
      end
      B_EMIT_INT: begin
        if (out_take) state_nxt = job_r.border ? B_EMIT_BRD : B_IDLE;
      end
      B_EMIT_BRD: begin
        if (out_take) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop_ready           = 1'b0;
    out_ch.valid        = 1'b0;
    out_ch.out_row      = job_r.row;
    out_ch.out_col      = job_r.col;
    out_ch.out_pixel    = job_r.px;
    out_ch.last_of_item = 1'b1;
    case (state_r)
      B_IDLE: pop_ready = 1'b1;
      B_EMIT_INT: begin
        out_ch.valid        = 1'b1;
        out_ch.out_row      = job_r.row - CNT_W'(1);
        out_ch.out_col      = job_r.col - CNT_W'(1);
        out_ch.out_pixel    = val_r;
        out_ch.last_of_item = !job_r.border;
      end
      B_EMIT_BRD: out_ch.valid = 1'b1;
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (pop) begin
          job_r <= pop_data;
          val_r <= pop_data.nb[CENTER_IDX];
        end
      end
      B_SUM: begin
        // quotient fits in a pixel, so the top bits start below the divisor
        rem_r   <= DEN_W'(num[NUM_W-1:PIX_W]);
        numlo_r <= num[PIX_W-1:0];
        den_r   <= {cnt, 1'b0};
        quo_r   <= '0;
        step_r  <= STEP_W'(DIV_STEPS - 1);
        if (cnt == '0) val_r <= '0;
      end
      B_DIV: begin
        rem_r   <= rem_step;
        numlo_r <= {numlo_r[PIX_W-2:0], 1'b0};
        quo_r   <= {quo_r[PIX_W-2:0], qbit};
        step_r  <= step_r - STEP_W'(1);
        if (step_r == '0) val_r <= {quo_r[PIX_W-2:0], qbit};
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[design/hole_fill_3x3_average.sv]
// Top level of the 3x3 neighborhood-average hole filler.
`timescale 1ns / 1ps
`default_nettype none

// Streams 8-bit gray pixels in raster order and fills holes: an interior zero pixel
// becomes the rounded mean of the nonzero pixels of its 3x3 neighborhood, and stays
// zero when all of them are zero. Border pixels come out as they arrive; an interior
// pixel (r,c) comes out when pixel (r+1,c+1) is taken, interior result first when
// both appear together. The front takes a new pixel only once the last one has
// been pushed to the queue (line-store read on accept, write-back on the push);
// the back takes a job only when idle, then sums the neighbors of a hole, runs an
// 8-step bit-serial divide when they are not all zero, and emits each result. A
// 4-entry job queue between the two absorbs bursts of holes. Width and height are
// clamped to 3..2048 and must only be written while the block is idle; the line
// stores are not cleared at reset and need no clearing pass.
module hole_fill_3x3_average (
  input  logic      clk,
  input  logic      rst_n,
  hfa_in_if.sink    in_ch,
  hfa_out_if.source out_ch,
  hfa_cfg_if.sink   cfg_ch
);
  import hfa_pkg::*;

  logic [DIM_W-1:0] width_r, height_r;
  logic [DIM_W-1:0] width_use, height_use;
  logic             push_valid, push_ready;
  logic             pop_valid, pop_ready;
  job_t             push_data, pop_data;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_ch.data;
        REG_IMAGE_HEIGHT: height_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign width_use  = dim_clamp(width_r, W_CAP);
  assign height_use = dim_clamp(height_r, H_CAP);

  hfa_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .width      (width_use),
    .height     (height_use),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  hfa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  hfa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

[sim/hole_fill_3x3_average_tb.sv]
// Self-checking testbench for the 3x3 hole filler: directed rows, then random frames.
`timescale 1ns / 1ps

module hole_fill_3x3_average_tb;
  import hfa_pkg::*;

  localparam int RAND_ITEMS    = 1750;
  localparam int SETTLE_CYCLES = 100;   // back end may still finish a queued hole
  localparam int QUIET_LIMIT   = 4000;  // cycles with no request moving on any channel

  // One emitted pixel as the result channel carries it
  typedef struct packed {
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic [PIX_W-1:0] pix;
    logic             last;
  } filled_px_t;

  typedef enum logic {
    DIR_PIXEL,
    DIR_CFG
  } dir_kind_t;

  // Directed row: a pixel request or a register write; ntyp < 0 means use the predictor
  typedef struct {
    dir_kind_t            kind;
    logic [PIX_W-1:0]     px;
    logic                 fs;
    logic [CFG_IDX_W-1:0] idx;
    logic [DIM_W-1:0]     data;
    int                   ntyp;
    filled_px_t           t0;
    filled_px_t           t1;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  hfa_in_if  in_if ();
  hfa_out_if out_if ();
  hfa_cfg_if cfg_if ();

  hole_fill_3x3_average DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #1 clk = ~clk;

  // Predictor state: two line stores, the six-entry window, position and registers
  logic [PIX_W-1:0] line_prev  [MAX_WIDTH];
  logic [PIX_W-1:0] line_prev2 [MAX_WIDTH];
  logic [PIX_W-1:0] win [WIN_N];
  int unsigned      pos_row;
  int unsigned      pos_col;
  logic [DIM_W-1:0] width_reg;
  logic [DIM_W-1:0] height_reg;

  filled_px_t pending_px [$];
  int         err_cnt = 0;
  int         quiet_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  // Fill one accepted pixel; returns the number of emitted pixels it causes
  function automatic int fill_step(input logic [PIX_W-1:0] px, input logic fs,
                                   output filled_px_t res [2]);
    int unsigned w, h, r, c, sum, cnt, val;
    int n;
    logic [PIX_W-1:0] a1, a2;
    logic [PIX_W-1:0] nb [9];
    n = 0;
    res[0] = '0;
    res[1] = '0;
    w = (width_reg < 3) ? 3 : ((width_reg > W_CAP_INT) ? W_CAP_INT : width_reg);
    h = (height_reg < 3) ? 3 : ((height_reg > CNT_LIMIT) ? CNT_LIMIT : height_reg);
    // frame start or a position outside the frame restarts at (0,0)
    if (fs || pos_col >= w || pos_row >= h) begin
      pos_row = 0;
      pos_col = 0;
    end
    r = pos_row;
    c = pos_col;
    a2 = line_prev2[c];
    a1 = line_prev[c];
    // interior pixel (r-1,c-1) is complete now
    if (r >= 2 && c >= 2) begin
      nb = '{win[0], win[3], a2, win[1], win[4], a1, win[2], win[5], px};
      val = win[4];
      if (win[4] == 0) begin
        sum = 0;
        cnt = 0;
        foreach (nb[i]) begin
          if (nb[i] != 0) begin
            sum += nb[i];
            cnt++;
          end
        end
        val = (cnt != 0) ? (2 * sum + cnt) / (2 * cnt) : 0;
      end
      res[n] = '{row: CNT_W'(r - 1), col: CNT_W'(c - 1), pix: PIX_W'(val), last: 1'b0};
      n++;
    end
    // border pixels pass straight through
    if (r == 0 || r == h - 1 || c == 0 || c == w - 1) begin
      res[n] = '{row: CNT_W'(r), col: CNT_W'(c), pix: px, last: 1'b0};
      n++;
    end
    if (n > 0) res[n - 1].last = 1'b1;
    line_prev2[c] = a1;
    line_prev[c]  = px;
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = a2;
    win[4] = a1;
    win[5] = px;
    if (c + 1 >= w) begin
      pos_col = 0;
      pos_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
    end
    return n;
  endfunction

  function automatic filled_px_t at_px(input int r, input int c, input int p);
    return '{row: CNT_W'(r), col: CNT_W'(c), pix: PIX_W'(p), last: 1'b0};
  endfunction

  function automatic dir_row_t px_row(input int px, input bit fs, input int ntyp = -1,
                                      input filled_px_t t0 = '0, input filled_px_t t1 = '0);
    dir_row_t d;
    d.kind = DIR_PIXEL;
    d.px   = PIX_W'(px);
    d.fs   = fs;
    d.idx  = REG_IMAGE_WIDTH;
    d.data = '0;
    d.ntyp = ntyp;
    d.t0   = t0;
    d.t1   = t1;
    return d;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input int data);
    dir_row_t d;
    d = px_row(0, 1'b0);
    d.kind = DIR_CFG;
    d.idx  = idx;
    d.data = DIM_W'(data);
    return d;
  endfunction

  // Pixel mix: holes, saturated, tiny and arbitrary values
  function automatic logic [PIX_W-1:0] rand_pixel(input int zero_pct);
    if ($urandom_range(99) < zero_pct) return '0;
    case ($urandom_range(3))
      0:       return 8'd255;
      1:       return PIX_W'($urandom_range(1, 3));
      default: return PIX_W'($urandom_range(1, 255));
    endcase
  endfunction

  // Mostly small frames, sometimes below the clamp, above it or a bit wider
  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(9))
      0:       return DIM_W'($urandom_range(0, 2));
      1:       return DIM_W'($urandom_range(9, 20));
      2:       return DIM_W'(4095);
      default: return DIM_W'($urandom_range(3, 8));
    endcase
  endfunction

  // Push one pixel request; expectations are queued at the accepting edge
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs, input int ntyp,
                            input filled_px_t t0, input filled_px_t t1);
    filled_px_t got [2];
    int n;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.pixel       <= px;
    in_if.frame_start <= fs;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    n = fill_step(px, fs, got);
    if (ntyp >= 0) begin
      got[0] = t0;
      got[1] = t1;
      n = ntyp;
    end
    for (int k = 0; k < n; k++) begin
      got[k].last = (k == n - 1);
      pending_px.push_back(got[k]);
    end
    @(negedge clk);
  endtask

  // Hold the sender until every expected pixel has come out
  task automatic pause_until_empty();
    in_if.valid <= 1'b0;
    @(negedge clk);
    while (pending_px.size() != 0) @(negedge clk);
  endtask

  // Register write, only with the block drained and settled
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
    pause_until_empty();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  width_reg  = data;
      REG_IMAGE_HEIGHT: height_reg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  // New geometry, then a stream of frames; noise adds frame starts mid-frame
  task automatic run_frames(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                            input int nitems, input int zero_pct, input int noise_pct);
    logic fs;
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    for (int k = 0; k < nitems; k++) begin
      if ($urandom_range(199) == 0) pause_until_empty();
      fs = (k == 0) || ($urandom_range(99) < noise_pct) ||
           (pos_row == 0 && pos_col == 0 && $urandom_range(1) == 1);
      send_pixel(rand_pixel(zero_pct), fs, -1, '0, '0);
    end
  endtask

  // Result checker: every accepted pixel against the oldest expectation
  always @(posedge clk) begin : check_results
    filled_px_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_px.size() == 0) begin
        $error("unexpected result row %0d col %0d pixel %0d", out_if.out_row, out_if.out_col,
               out_if.out_pixel);
        err_cnt++;
      end else begin
        want = pending_px.pop_front();
        if (out_if.out_row !== want.row) begin
          $error("out_row: expected %0d, got %0d", want.row, out_if.out_row);
          err_cnt++;
        end
        if (out_if.out_col !== want.col) begin
          $error("out_col: expected %0d, got %0d", want.col, out_if.out_col);
          err_cnt++;
        end
        if (out_if.out_pixel !== want.pix) begin
          $error("out_pixel: expected %0d, got %0d", want.pix, out_if.out_pixel);
          err_cnt++;
        end
        if (out_if.last_of_item !== want.last) begin
          $error("last_of_item: expected %0d, got %0d", want.last, out_if.last_of_item);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog on channel activity
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("hole_fill_3x3_average_tb: errors");
        $finish;
      end
    end
  end

  // Result side back-pressure
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Stimulus
  initial begin
    dir_row_t dir_tab [$];
    int rand_sent;
    int nitems;
    int zero_pct;
    int noise_pct;
    in_if.valid       = 1'b0;
    in_if.pixel       = '0;
    in_if.frame_start = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_IMAGE_WIDTH;
    cfg_if.data       = '0;
    // predictor reset
    foreach (line_prev[i]) begin
      line_prev[i]  = '0;
      line_prev2[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    pos_row    = 0;
    pos_col    = 0;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;

    // after reset the frame is 640x480: row 0 is border and comes out at once
    dir_tab.push_back(px_row(255, 1'b1, 1, at_px(0, 0, 255)));
    dir_tab.push_back(px_row(0,   1'b0, 1, at_px(0, 1, 0)));
    dir_tab.push_back(px_row(128, 1'b0, 1, at_px(0, 2, 128)));
    dir_tab.push_back(px_row(1,   1'b0, 1, at_px(0, 3, 1)));
    // both below the clamp: 3x3 frame
    dir_tab.push_back(cfg_row(REG_IMAGE_WIDTH, 0));
    dir_tab.push_back(cfg_row(REG_IMAGE_HEIGHT, 2));
    // (0,4) is now outside the frame and restarts at (0,0); hole ringed by 255s
    dir_tab.push_back(px_row(255, 1'b0, 1, at_px(0, 0, 255)));
    dir_tab.push_back(px_row(255, 1'b0, 1, at_px(0, 1, 255)));
    dir_tab.push_back(px_row(255, 1'b0, 1, at_px(0, 2, 255)));
    dir_tab.push_back(px_row(255, 1'b0, 1, at_px(1, 0, 255)));
    dir_tab.push_back(px_row(0,   1'b0, 0));
    dir_tab.push_back(px_row(255, 1'b0, 1, at_px(1, 2, 255)));
    dir_tab.push_back(px_row(255, 1'b0, 1, at_px(2, 0, 255)));
    dir_tab.push_back(px_row(255, 1'b0, 1, at_px(2, 1, 255)));
    dir_tab.push_back(px_row(255, 1'b0, 2, at_px(1, 1, 255), at_px(2, 2, 255)));
    // 4x3: one all-zero neighborhood, one hole with a rounded mean
    dir_tab.push_back(cfg_row(REG_IMAGE_WIDTH, 4));
    dir_tab.push_back(cfg_row(REG_IMAGE_HEIGHT, 3));
    dir_tab.push_back(px_row(0,   1'b1));
    dir_tab.push_back(px_row(0,   1'b0));
    dir_tab.push_back(px_row(0,   1'b0));
    dir_tab.push_back(px_row(9,   1'b0));
    dir_tab.push_back(px_row(0,   1'b0));
    dir_tab.push_back(px_row(0,   1'b0));
    dir_tab.push_back(px_row(0,   1'b0));
    dir_tab.push_back(px_row(255, 1'b0));
    dir_tab.push_back(px_row(0,   1'b0));
    dir_tab.push_back(px_row(0,   1'b0));
    dir_tab.push_back(px_row(0,   1'b0));
    dir_tab.push_back(px_row(200, 1'b0));

    // synchronous reset, released at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 12;
    recv_idle_pct = 51;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == DIR_CFG) begin
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_pixel(dir_tab[i].px, dir_tab[i].fs, dir_tab[i].ntyp, dir_tab[i].t0, dir_tab[i].t1);
      end
    end

    // random frames; idling shifts from sender-light to receiver-light to none
    rand_sent = 0;
    while (rand_sent < RAND_ITEMS) begin
      case (rand_sent * 3 / RAND_ITEMS)
        0: begin
          send_idle_pct = 12;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 12;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case ($urandom_range(2))
        0:       zero_pct = 15;
        1:       zero_pct = 50;
        default: zero_pct = 85;
      endcase
      noise_pct = ($urandom_range(3) == 0) ? 4 : 0;
      nitems = $urandom_range(20, 110);
      run_frames(pick_dim(), pick_dim(), nitems, zero_pct, noise_pct);
      rand_sent += nitems;
    end

    pause_until_empty();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (err_cnt == 0 && pending_px.size() == 0) begin
      $display("hole_fill_3x3_average_tb: clean");
    end else begin
      $display("hole_fill_3x3_average_tb: errors");
    end
    $finish;
  end

endmodule

[hole_fill_3x3_average.f]
design/hfa_pkg.sv
design/hfa_if.sv
design/hfa_front.sv
design/hfa_queue.sv
design/hfa_back.sv
design/hole_fill_3x3_average.sv
sim/hole_fill_3x3_average_tb.sv
